>>> sv/fcmb_pkg.sv
`default_nettype none

package fcmb_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_COUNT    = 3'd2,
      CMD_CONTAINS = 3'd3,
      CMD_CLEAR    = 3'd4,
      CMD_DUMP     = 3'd5
   } cmd_type;

   typedef struct packed {
      logic accept;
      logic decode_do;
      logic scan_start;
      logic scan_run;
      logic rmv_rd;
      logic rmv_wr;
      logic dump_load;
      logic fin_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_add;
      logic is_remove;
      logic is_count;
      logic is_contains;
      logic is_clear;
      logic is_dump;
      logic occ_zero;
      logic scan_done;
      logic found;
      logic out_free;
      logic dump_last;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/fixed_capacity_multiset_bag.sv
`default_nettype none

// Unordered multiset of up to CAPACITY values in a single-port-read RAM plus an
// occupancy count. One request word is taken at a time; the next is accepted the
// cycle after the previous command has placed its last response word in the output
// register, so a response may still be waiting when the next request goes in. Add,
// clear, unknown commands and a dump of an empty bag go from decode straight to
// the final state, which loads their response. Remove, count and contains walk
// the stored entries one per cycle through the RAM read port; a remove that finds
// its value then reads the last entry and writes it over the match (move-last).
// Dump streams one response word per cycle when the output side keeps up; an empty
// bag gives a single word with entry_valid low; a load waits on an output stall.
// The store is not cleared after reset: only entries below the occupancy are read.

module fixed_capacity_multiset_bag #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [fcmb_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [fcmb_pkg::VALUE_W-1:0]      req_value,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_ok,
   output      logic [fcmb_pkg::COUNT_W-1:0]      rsp_frequency,
   output      logic [fcmb_pkg::COUNT_W-1:0]      rsp_size,
   output      logic                              rsp_is_empty,
   output      logic [fcmb_pkg::VALUE_W-1:0]      rsp_entry,
   output      logic                              rsp_entry_valid,
   output      logic                              rsp_last
);

   fcmb_pkg::ctrl_cmd_type  cmd;
   fcmb_pkg::dp_status_type status;

   fcmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcmb_dpath #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_frequency   (rsp_frequency),
      .rsp_size        (rsp_size),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry       (rsp_entry),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

>>> sv/fcmb_ram.sv
`default_nettype none

module fcmb_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output      logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/fcmb_ctrl.sv
`default_nettype none

module fcmb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire fcmb_pkg::dp_status_type status,
   output      fcmb_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DECODE  = 8'b0000_0010,
      ST_SCAN    = 8'b0000_0100,
      ST_RMV_RD  = 8'b0000_1000,
      ST_RMV_WR  = 8'b0001_0000,
      ST_DUMP_RD = 8'b0010_0000,
      ST_DUMP_LD = 8'b0100_0000,
      ST_FIN     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode_do  = 1'b1;
            cmd.scan_start = 1'b1;
            if (status.is_remove || status.is_count || status.is_contains) begin
               state_in = ST_SCAN;
            end else if (status.is_dump && !status.occ_zero) begin
               state_in = ST_DUMP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = (status.is_remove && status.found) ? ST_RMV_RD : ST_FIN;
            end
         end
         ST_RMV_RD: begin
            cmd.rmv_rd = 1'b1;
            state_in   = ST_RMV_WR;
         end
         ST_RMV_WR: begin
            cmd.rmv_wr = 1'b1;
            state_in   = ST_FIN;
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_LD;
         end
         ST_DUMP_LD: begin
            if (status.out_free) begin
               cmd.dump_load = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.fin_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/fcmb_dpath.sv
`default_nettype none

module fcmb_dpath #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [fcmb_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [fcmb_pkg::VALUE_W-1:0]      req_value,
   input  wire fcmb_pkg::ctrl_cmd_type            cmd,
   output      fcmb_pkg::dp_status_type           status,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_ok,
   output      logic [fcmb_pkg::COUNT_W-1:0]      rsp_frequency,
   output      logic [fcmb_pkg::COUNT_W-1:0]      rsp_size,
   output      logic                              rsp_is_empty,
   output      logic [fcmb_pkg::VALUE_W-1:0]      rsp_entry,
   output      logic                              rsp_entry_valid,
   output      logic                              rsp_last
);

   localparam int STORE_W = (ITEM_WIDTH < fcmb_pkg::VALUE_W) ? ITEM_WIDTH : fcmb_pkg::VALUE_W;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   logic [fcmb_pkg::CMD_W-1:0] cmd_ff;
   logic [STORE_W-1:0]         value_ff;
   logic [CNT_W-1:0]           occ_ff;
   logic [CNT_W-1:0]           rd_idx_ff;
   logic                       cmp_vld_ff;
   logic [IDX_W-1:0]           cmp_idx_ff;
   logic [CNT_W-1:0]           freq_ff;
   logic                       found_ff;
   logic [IDX_W-1:0]           found_idx_ff;
   logic                       add_ok_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_ok_ff;
   logic [fcmb_pkg::COUNT_W-1:0] rsp_frequency_ff;
   logic [fcmb_pkg::COUNT_W-1:0] rsp_size_ff;
   logic                       rsp_is_empty_ff;
   logic [fcmb_pkg::VALUE_W-1:0] rsp_entry_ff;
   logic                       rsp_entry_valid_ff;
   logic                       rsp_last_ff;

   logic                       ram_we;
   logic [IDX_W-1:0]           ram_waddr;
   logic [STORE_W-1:0]         ram_wdata;
   logic [IDX_W-1:0]           ram_raddr;
   logic [STORE_W-1:0]         ram_rdata;

   logic                       is_add, is_remove, is_count, is_contains, is_clear, is_dump;
   logic                       room;
   logic                       issue;
   logic                       match;
   logic [CNT_W-1:0]           occ_dec;
   logic [CNT_W-1:0]           rd_idx_inc;
   logic                       fin_ok;

   assign is_add      = (cmd_ff == fcmb_pkg::CMD_ADD);
   assign is_remove   = (cmd_ff == fcmb_pkg::CMD_REMOVE);
   assign is_count    = (cmd_ff == fcmb_pkg::CMD_COUNT);
   assign is_contains = (cmd_ff == fcmb_pkg::CMD_CONTAINS);
   assign is_clear    = (cmd_ff == fcmb_pkg::CMD_CLEAR);
   assign is_dump     = (cmd_ff == fcmb_pkg::CMD_DUMP);

   assign room       = (occ_ff < CAP_CNT);
   assign issue      = cmd.scan_run && (rd_idx_ff < occ_ff);
   assign match      = cmp_vld_ff && (ram_rdata == value_ff);
   assign occ_dec    = occ_ff - ONE_CNT;
   assign rd_idx_inc = rd_idx_ff + ONE_CNT;

   always_comb begin
      priority if (cmd.rmv_rd) begin
         ram_raddr = occ_dec[IDX_W-1:0];
      end else if (cmd.dump_load) begin
         ram_raddr = rd_idx_inc[IDX_W-1:0];
      end else begin
         ram_raddr = rd_idx_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = occ_ff[IDX_W-1:0];
      ram_wdata = value_ff;
      if (cmd.decode_do && is_add && room) begin
         ram_we = 1'b1;
      end else if (cmd.rmv_wr) begin
         ram_we    = 1'b1;
         ram_waddr = found_idx_ff;
         ram_wdata = ram_rdata;
      end
   end

   fcmb_ram #(
      .WIDTH (STORE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value[STORE_W-1:0];
      end
      if (cmd.decode_do) begin
         add_ok_ff <= room;
      end
      if (cmd.scan_start) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         freq_ff    <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (cmd.scan_run) begin
            cmp_vld_ff <= issue;
            cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
            if (issue) begin
               rd_idx_ff <= rd_idx_inc;
            end
            if (match) begin
               freq_ff <= freq_ff + ONE_CNT;
               if (!found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= cmp_idx_ff;
               end
            end
         end
         if (cmd.dump_load) begin
            rd_idx_ff <= rd_idx_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.decode_do && is_add && room) begin
         occ_ff <= occ_ff + ONE_CNT;
      end else if (cmd.decode_do && is_clear) begin
         occ_ff <= '0;
      end else if (cmd.rmv_wr) begin
         occ_ff <= occ_dec;
      end
   end

   always_comb begin
      priority if (is_add) begin
         fin_ok = add_ok_ff;
      end else if (is_clear) begin
         fin_ok = 1'b1;
      end else if (is_remove || is_contains) begin
         fin_ok = found_ff;
      end else begin
         fin_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin_load || cmd.dump_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_load) begin
         rsp_ok_ff          <= fin_ok;
         rsp_frequency_ff   <= is_count ? fcmb_pkg::COUNT_W'(freq_ff) : '0;
         rsp_size_ff        <= fcmb_pkg::COUNT_W'(occ_ff);
         rsp_is_empty_ff    <= (occ_ff == '0);
         rsp_entry_ff       <= '0;
         rsp_entry_valid_ff <= 1'b0;
         rsp_last_ff        <= 1'b1;
      end else if (cmd.dump_load) begin
         rsp_ok_ff          <= 1'b1;
         rsp_frequency_ff   <= '0;
         rsp_size_ff        <= fcmb_pkg::COUNT_W'(occ_ff);
         rsp_is_empty_ff    <= (occ_ff == '0);
         rsp_entry_ff       <= fcmb_pkg::VALUE_W'(ram_rdata);
         rsp_entry_valid_ff <= 1'b1;
         rsp_last_ff        <= (rd_idx_inc == occ_ff);
      end
   end

   assign status.is_add      = is_add;
   assign status.is_remove   = is_remove;
   assign status.is_count    = is_count;
   assign status.is_contains = is_contains;
   assign status.is_clear    = is_clear;
   assign status.is_dump     = is_dump;
   assign status.occ_zero    = (occ_ff == '0);
   assign status.scan_done   = !(rd_idx_ff < occ_ff) && !cmp_vld_ff;
   assign status.found       = found_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.dump_last   = (rd_idx_inc == occ_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_frequency   = rsp_frequency_ff;
   assign rsp_size        = rsp_size_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry       = rsp_entry_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

>>> tb/sv/fixed_capacity_multiset_bag_tb.sv
`default_nettype none

module fixed_capacity_multiset_bag_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_W   = fcmb_pkg::CMD_W;
   localparam int VALUE_W = fcmb_pkg::VALUE_W;
   localparam int COUNT_W = fcmb_pkg::COUNT_W;

   localparam int BAG_DEPTH = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_WORDS = 360;
   localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] frequency;
      logic [COUNT_W-1:0] size;
      logic               is_empty;
      logic [VALUE_W-1:0] entry;
      logic               entry_valid;
      logic               last;
   } bag_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_cmd = fcmb_pkg::CMD_ADD;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [COUNT_W-1:0] rsp_frequency;
   logic [COUNT_W-1:0] rsp_size;
   logic               rsp_is_empty;
   logic [VALUE_W-1:0] rsp_entry;
   logic               rsp_entry_valid;
   logic               rsp_last;

   logic [VALUE_W-1:0] shadow_slots [BAG_DEPTH];
   int                 shadow_fill = 0;
   bag_rsp_type        pending_rsp [$];
   int                 fail_count = 0;
   int                 words_sent = 0;
   bit                 quiet_mode = 1'b0;
   int                 ready_stall = 0;

   fixed_capacity_multiset_bag #(
      .CAPACITY(BAG_DEPTH),
      .ITEM_WIDTH(VALUE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_frequency(rsp_frequency),
      .rsp_size(rsp_size),
      .rsp_is_empty(rsp_is_empty),
      .rsp_entry(rsp_entry),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_last(rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_rsp(logic ok, logic [COUNT_W-1:0] freq,
                                     logic [VALUE_W-1:0] ent, logic ent_valid,
                                     logic fin);
      bag_rsp_type r;
      r.ok          = ok;
      r.frequency   = freq;
      r.size        = COUNT_W'(shadow_fill);
      r.is_empty    = (shadow_fill == 0);
      r.entry       = ent;
      r.entry_valid = ent_valid;
      r.last        = fin;
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic void bag_apply(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      int hit;
      int freq;
      hit  = -1;
      freq = 0;
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_slots[i] == value) begin
            freq++;
            if (hit < 0) hit = i;
         end
      end
      case (cmd)
         fcmb_pkg::CMD_ADD: begin
            if (shadow_fill < BAG_DEPTH) begin
               shadow_slots[shadow_fill] = value;
               shadow_fill++;
               queue_rsp(1'b1, '0, '0, 1'b0, 1'b1);
            end else begin
               queue_rsp(1'b0, '0, '0, 1'b0, 1'b1);
            end
         end
         fcmb_pkg::CMD_REMOVE: begin
            if (hit >= 0) begin
               shadow_fill--;
               shadow_slots[hit] = shadow_slots[shadow_fill];
               queue_rsp(1'b1, '0, '0, 1'b0, 1'b1);
            end else begin
               queue_rsp(1'b0, '0, '0, 1'b0, 1'b1);
            end
         end
         fcmb_pkg::CMD_COUNT:    queue_rsp(1'b0, COUNT_W'(freq), '0, 1'b0, 1'b1);
         fcmb_pkg::CMD_CONTAINS: queue_rsp(hit >= 0, '0, '0, 1'b0, 1'b1);
         fcmb_pkg::CMD_CLEAR: begin
            shadow_fill = 0;
            queue_rsp(1'b1, '0, '0, 1'b0, 1'b1);
         end
         fcmb_pkg::CMD_DUMP: begin
            if (shadow_fill == 0) queue_rsp(1'b0, '0, '0, 1'b0, 1'b1);
            for (int i = 0; i < shadow_fill; i++)
               queue_rsp(1'b1, '0, shadow_slots[i], 1'b1, i == shadow_fill - 1);
         end
         default:      queue_rsp(1'b0, '0, '0, 1'b0, 1'b1);
      endcase
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bag_apply(cmd, value);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      bag_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing pending");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("ok", want.ok, rsp_ok);
            check_field("frequency", want.frequency, rsp_frequency);
            check_field("size", want.size, rsp_size);
            check_field("is_empty", want.is_empty, rsp_is_empty);
            check_field("entry", want.entry, rsp_entry);
            check_field("entry_valid", want.entry_valid, rsp_entry_valid);
            check_field("last", want.last, rsp_last);
         end
      end
      if (!quiet_mode && ready_stall == 0 && $urandom_range(0, 3) == 0)
         ready_stall = pick_gap();
      if (!quiet_mode && ready_stall > 0) begin
         ready_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_empty_bag();
      send_word(fcmb_pkg::CMD_DUMP, 32'h0000_0000);
      send_word(fcmb_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
      send_word(fcmb_pkg::CMD_CONTAINS, 32'h0000_0000);
      send_word(CMD_RSVD6, 32'hA5A5_5A5A);
      send_word(CMD_RSVD7, 32'h5A5A_A5A5);
      wait_drained();
   endtask

   task automatic test_fill_to_capacity();
      repeat (BAG_DEPTH) send_word(fcmb_pkg::CMD_ADD, 32'hFFFF_FFFF);
      send_word(fcmb_pkg::CMD_ADD, 32'h0000_0000);
      send_word(fcmb_pkg::CMD_COUNT, 32'hFFFF_FFFF);
      send_word(fcmb_pkg::CMD_DUMP, 32'h0000_0000);
      send_word(fcmb_pkg::CMD_CLEAR, 32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_random_sequences();
      logic [VALUE_W-1:0] pool [4];
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      int                 pool_size;
      int                 seq_len;
      int                 r;
      while (words_sent < RANDOM_WORDS) begin
         quiet_mode = ($urandom_range(0, 3) == 0);
         pool_size  = $urandom_range(1, 4);
         foreach (pool[i]) begin
            r = $urandom_range(0, 3);
            pool[i] = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF :
                      (r == 2) ? VALUE_W'($urandom_range(0, 7)) : $urandom();
         end
         seq_len = $urandom_range(4, 24);
         repeat (seq_len) begin
            r = $urandom_range(0, 99);
            if (r < 40)      cmd = fcmb_pkg::CMD_ADD;
            else if (r < 60) cmd = fcmb_pkg::CMD_REMOVE;
            else if (r < 72) cmd = fcmb_pkg::CMD_COUNT;
            else if (r < 84) cmd = fcmb_pkg::CMD_CONTAINS;
            else if (r < 92) cmd = fcmb_pkg::CMD_DUMP;
            else if (r < 95) cmd = fcmb_pkg::CMD_CLEAR;
            else             cmd = CMD_W'($urandom_range(0, 7));
            value = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                                 : $urandom();
            send_word(cmd, value);
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_bag();
      test_fill_to_capacity();
      test_random_sequences();
      wait_drained();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
sv/fcmb_pkg.sv
sv/fcmb_ram.sv
sv/fcmb_ctrl.sv
sv/fcmb_dpath.sv
sv/fixed_capacity_multiset_bag.sv
tb/sv/fixed_capacity_multiset_bag_tb.sv
